>>> rtl/famrs_pkg.sv
// ----------------------------------------------------------------------------
// famrs_pkg
// Shared types and constants for the fault-aware mesh route selector.
// ----------------------------------------------------------------------------
package famrs_pkg;

  localparam int NODE_ID_BITS = 8;
  localparam int MAX_FAULTS   = 16;
  localparam int COL_W        = 5;
  localparam int FC_W         = 5;
  localparam int CFG_DATA_W   = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int SLOT_W       = $clog2(MAX_FAULTS);
  localparam int NB_W         = NODE_ID_BITS + 2;
  localparam int DIV_STEPS    = 2;
  localparam int DIV_STAGES   = (NODE_ID_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DVD_W        = DIV_STAGES * DIV_STEPS;
  localparam int FLAG_DLY     = DIV_STAGES - 2;

  typedef logic [NODE_ID_BITS-1:0] node_id_t;
  typedef logic [COL_W-1:0]        col_t;
  typedef logic [DVD_W-1:0]        quo_t;

  typedef enum logic [2:0] {
    PORT_NONE  = 3'd0,
    PORT_NORTH = 3'd1,
    PORT_EAST  = 3'd2,
    PORT_SOUTH = 3'd3,
    PORT_WEST  = 3'd4,
    PORT_LOCAL = 3'd5
  } port_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROUTER_ID    = 2'd0,
    CFG_MESH_COLUMNS = 2'd1,
    CFG_FAULT_COUNT  = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_ROUTE = 1'b1
  } req_t;

  // Per-neighbor link status: own link faulty, neighbor touches any fault
  typedef struct packed {
    logic dead_n;
    logic dead_e;
    logic dead_s;
    logic dead_w;
    logic mark_n;
    logic mark_e;
    logic mark_s;
    logic mark_w;
  } link_flags_t;

  typedef struct packed {
    quo_t quo;
    col_t rem;
  } div_res_t;

endpackage

>>> rtl/famrs_div_pipe.sv
// ----------------------------------------------------------------------------
// famrs_div_pipe
// Pipelined restoring divider, two lanes (destination and router id),
// two quotient bits per stage.
// ----------------------------------------------------------------------------
module famrs_div_pipe
  import famrs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_vld,
  input  node_id_t in_dest,
  input  node_id_t in_id,
  input  col_t     divisor,
  output logic     out_vld,
  output div_res_t out_dest,
  output div_res_t out_id
);

  logic vld_r   [DIV_STAGES];
  logic stg_en  [DIV_STAGES];
  col_t rem_r   [2][DIV_STAGES];
  col_t rem_nxt [2][DIV_STAGES];
  quo_t quo_r   [2][DIV_STAGES];
  quo_t quo_nxt [2][DIV_STAGES];
  quo_t dvd_r   [2][DIV_STAGES];
  quo_t dvd_nxt [2][DIV_STAGES];

  always_comb begin
    col_t           rem;
    quo_t           quo;
    quo_t           dvd;
    logic [COL_W:0] r6;
    for (int s = 0; s < DIV_STAGES; s++) begin
      stg_en[s] = (s == 0) ? in_vld : vld_r[(s == 0) ? 0 : s - 1];
      for (int l = 0; l < 2; l++) begin
        if (s == 0) begin
          rem = '0;
          quo = '0;
          dvd = (l == 0) ? DVD_W'(in_dest) : DVD_W'(in_id);
        end else begin
          rem = rem_r[l][s-1];
          quo = quo_r[l][s-1];
          dvd = dvd_r[l][s-1];
        end
        for (int j = 0; j < DIV_STEPS; j++) begin
          r6  = {rem, dvd[DVD_W-1]};
          dvd = dvd << 1;
          if (r6 >= {1'b0, divisor}) begin
            rem = COL_W'(r6 - {1'b0, divisor});
            quo = {quo[DVD_W-2:0], 1'b1};
          end else begin
            rem = r6[COL_W-1:0];
            quo = {quo[DVD_W-2:0], 1'b0};
          end
        end
        rem_nxt[l][s] = rem;
        quo_nxt[l][s] = quo;
        dvd_nxt[l][s] = dvd;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= stg_en[s];
      end
    end
  end

  // Advance payload only behind a valid beat
  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (stg_en[s]) begin
        for (int l = 0; l < 2; l++) begin
          rem_r[l][s] <= rem_nxt[l][s];
          quo_r[l][s] <= quo_nxt[l][s];
          dvd_r[l][s] <= dvd_nxt[l][s];
        end
      end
    end
  end

  assign out_vld  = vld_r[DIV_STAGES-1];
  assign out_dest = '{quo: quo_r[0][DIV_STAGES-1], rem: rem_r[0][DIV_STAGES-1]};
  assign out_id   = '{quo: quo_r[1][DIV_STAGES-1], rem: rem_r[1][DIV_STAGES-1]};

  a_vld_travels: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> $past(in_vld, DIV_STAGES))
    else $error("divider result without a matching input beat");

endmodule

>>> rtl/famrs_fault_scan.sv
// ----------------------------------------------------------------------------
// famrs_fault_scan
// Faulty-link table with a two-stage scan: per-entry compares, then OR tree.
// ----------------------------------------------------------------------------
module famrs_fault_scan
  import famrs_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] wr_slot,
  input  node_id_t          wr_low,
  input  node_id_t          wr_high,
  input  node_id_t          router_id,
  input  col_t              divisor,
  input  logic [FC_W-1:0]   fault_count,
  output link_flags_t       flags
);

  node_id_t    tab_lo_r  [MAX_FAULTS];
  node_id_t    tab_hi_r  [MAX_FAULTS];
  link_flags_t hit_r     [MAX_FAULTS];
  link_flags_t hit_nxt   [MAX_FAULTS];
  link_flags_t flags_r;
  link_flags_t flags_nxt;

  logic [NB_W-1:0] sid;
  logic [NB_W-1:0] n_n;
  logic [NB_W-1:0] n_e;
  logic [NB_W-1:0] n_s;
  logic [NB_W-1:0] n_w;

  // Off-mesh neighbors wrap to values no 8-bit entry can equal
  assign sid = NB_W'(router_id);
  assign n_e = sid + NB_W'(1);
  assign n_w = sid - NB_W'(1);
  assign n_n = sid - NB_W'(divisor);
  assign n_s = sid + NB_W'(divisor);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tab_lo_r[wr_slot] <= wr_low;
      tab_hi_r[wr_slot] <= wr_high;
    end
  end

  always_comb begin
    logic            en;
    logic [NB_W-1:0] lo;
    logic [NB_W-1:0] hi;
    for (int i = 0; i < MAX_FAULTS; i++) begin
      en = (32'(fault_count) > 32'(i));
      lo = NB_W'(tab_lo_r[i]);
      hi = NB_W'(tab_hi_r[i]);
      hit_nxt[i].dead_e = en && (lo == sid) && (hi == n_e);
      hit_nxt[i].dead_s = en && (lo == sid) && (hi == n_s);
      hit_nxt[i].dead_w = en && (hi == sid) && (lo == n_w);
      hit_nxt[i].dead_n = en && (hi == sid) && (lo == n_n);
      hit_nxt[i].mark_e = en && ((lo == n_e) || (hi == n_e));
      hit_nxt[i].mark_w = en && ((lo == n_w) || (hi == n_w));
      hit_nxt[i].mark_n = en && ((lo == n_n) || (hi == n_n));
      hit_nxt[i].mark_s = en && ((lo == n_s) || (hi == n_s));
    end
  end

  always_comb begin
    flags_nxt = '0;
    for (int i = 0; i < MAX_FAULTS; i++) begin
      flags_nxt = flags_nxt | hit_r[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_FAULTS; i++) begin
      hit_r[i] <= hit_nxt[i];
    end
    flags_r <= flags_nxt;
  end

  assign flags = flags_r;

endmodule

>>> rtl/fault_aware_mesh_route_select.sv
// ----------------------------------------------------------------------------
// fault_aware_mesh_route_select
// Output-port selection for one 2D-mesh router with a faulty-link table.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats are taken at a rising edge with start high and busy low.
//   in_req_type selects a load beat (writes in_link_end_low/high into table
//   slot in_fault_slot, no result) or a route beat (routes in_dest_node).
//   Each route beat gives one result: out_valid is high for exactly one
//   cycle with out_port, and the sink takes it at the edge ending that cycle.
//   Path: a route beat passes one input register, four divider stages and
//   one output register before out_valid rises.
//   Throughput: one beat per cycle while busy is low, loads and routes
//   mixed freely; the divider retires two quotient bits per stage per cycle.
//   Configuration (router_id, mesh_columns, fault_count) goes over the cfg_
//   channel, always ready; the user must change it only while the pipeline is empty, unchecked by the block.
//   Reset: config returns to id 0, 4 columns, no faults; busy is registered,
//   high while reset is held, and drops once a clock edge samples reset
//   released. The fault table keeps its contents.
//   The sink cannot stall, so results are never held.
// ----------------------------------------------------------------------------
module fault_aware_mesh_route_select
  import famrs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_req_type,
  input  logic [3:0]            in_fault_slot,
  input  logic [7:0]            in_link_end_low,
  input  logic [7:0]            in_link_end_high,
  input  logic [7:0]            in_dest_node,
  // result channel
  output logic                  out_valid,
  output logic [2:0]            out_port,
  // configuration channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int OUT_LAT = DIV_STAGES + 2;

  // Config registers
  node_id_t        router_id_r;
  logic [COL_W-1:0] mesh_columns_r;
  logic [FC_W-1:0] fault_count_r;
  col_t            cols_eff;

  logic busy_r;
  logic in_acc;
  logic route_acc;
  logic load_acc;

  // Stage 0: captured route beat
  logic     vld0_r;
  node_id_t dest0_r;

  // Divider results
  logic     div_vld;
  div_res_t div_dest;
  div_res_t div_id;

  // Link flags, delayed to line up with the divider output
  link_flags_t scan_flags;
  link_flags_t fl_r [FLAG_DLY];
  link_flags_t fl_cur;

  // Output register
  logic  out_valid_r;
  port_t out_port_r;
  port_t port_nxt;

  assign busy      = busy_r;
  assign cfg_ready = 1'b1;
  assign in_acc    = start && !busy_r;
  assign route_acc = in_acc && (in_req_type == REQ_ROUTE);
  assign load_acc  = in_acc && (in_req_type == REQ_LOAD)
                     && (32'(in_fault_slot) < 32'(MAX_FAULTS));

  // Zero columns is treated as one column
  assign cols_eff = (mesh_columns_r == '0) ? col_t'(1) : mesh_columns_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // Config writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      router_id_r    <= '0;
      mesh_columns_r <= COL_W'(4);
      fault_count_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROUTER_ID:    router_id_r    <= cfg_data[NODE_ID_BITS-1:0];
        CFG_MESH_COLUMNS: mesh_columns_r <= cfg_data[COL_W-1:0];
        CFG_FAULT_COUNT:  fault_count_r  <= cfg_data[FC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= route_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (route_acc) begin
      dest0_r <= in_dest_node;
    end
  end

  famrs_div_pipe u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld0_r),
    .in_dest  (dest0_r),
    .in_id    (router_id_r),
    .divisor  (cols_eff),
    .out_vld  (div_vld),
    .out_dest (div_dest),
    .out_id   (div_id)
  );

  // Table writes land at the accept edge, so a route sees every earlier load
  famrs_fault_scan u_scan (
    .clk         (clk),
    .wr_en       (load_acc),
    .wr_slot     (in_fault_slot[SLOT_W-1:0]),
    .wr_low      (in_link_end_low),
    .wr_high     (in_link_end_high),
    .router_id   (router_id_r),
    .divisor     (cols_eff),
    .fault_count (fault_count_r),
    .flags       (scan_flags)
  );

  always_ff @(posedge clk) begin
    for (int k = 0; k < FLAG_DLY; k++) begin
      fl_r[k] <= (k == 0) ? scan_flags : fl_r[(k == 0) ? 0 : k - 1];
    end
  end

  assign fl_cur = fl_r[FLAG_DLY-1];

  // Final decision: local hit, productive directions, drop dead links, break ties
  always_comb begin
    port_t hdir;
    port_t vdir;
    logic  hmark;
    logic  vmark;
    logic  pick_v;
    hdir = PORT_NONE;
    vdir = PORT_NONE;
    if (div_dest.rem > div_id.rem) begin
      hdir = PORT_EAST;
    end else if (div_dest.rem < div_id.rem) begin
      hdir = PORT_WEST;
    end
    if (div_dest.quo < div_id.quo) begin
      vdir = PORT_NORTH;
    end else if (div_dest.quo > div_id.quo) begin
      vdir = PORT_SOUTH;
    end
    if ((hdir == PORT_EAST && fl_cur.dead_e) || (hdir == PORT_WEST && fl_cur.dead_w)) begin
      hdir = PORT_NONE;
    end
    if ((vdir == PORT_NORTH && fl_cur.dead_n) || (vdir == PORT_SOUTH && fl_cur.dead_s)) begin
      vdir = PORT_NONE;
    end
    hmark  = (hdir == PORT_EAST) ? fl_cur.mark_e : fl_cur.mark_w;
    vmark  = (vdir == PORT_NORTH) ? fl_cur.mark_n : fl_cur.mark_s;
    pick_v = (hmark == vmark) ? router_id_r[0] : hmark;
    if (div_dest == div_id) begin
      port_nxt = PORT_LOCAL;
    end else if (hdir == PORT_NONE) begin
      port_nxt = vdir;
    end else if (vdir == PORT_NONE) begin
      port_nxt = hdir;
    end else begin
      port_nxt = pick_v ? vdir : hdir;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (div_vld) begin
      out_port_r <= port_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_port  = out_port_r;

  a_result_from_route: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(route_acc, OUT_LAT))
    else $error("result strobe without a route beat");

  a_no_dead_h: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !((out_port_r == PORT_EAST && $past(fl_cur.dead_e))
                   || (out_port_r == PORT_WEST && $past(fl_cur.dead_w))))
    else $error("horizontal port chosen over a faulty link");

  a_no_dead_v: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !((out_port_r == PORT_NORTH && $past(fl_cur.dead_n))
                   || (out_port_r == PORT_SOUTH && $past(fl_cur.dead_s))))
    else $error("vertical port chosen over a faulty link");

endmodule

>>> tb/tb_fault_aware_mesh_route_select.sv
// ----------------------------------------------------------------------------
// tb_fault_aware_mesh_route_select
// Self-checking bench for the fault-aware mesh route selector: drives load and
// route beats with random gaps and computes each expected output port from a
// behavioral copy of the register set and the faulty-link table. Every result
// strobe is checked against the oldest expected port.
// ----------------------------------------------------------------------------
module tb_fault_aware_mesh_route_select
  import famrs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Idle cycles to let the pipeline empty before touching the registers.
  // Loads give no strobe, so the last strobe does not prove the pipe is empty.
  localparam int SETTLE_CYCLES = 10;
  // Cycles without any accepted beat before the run is declared hung.
  localparam int HANG_LIMIT    = 2000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_req_type = 1'b0;
  logic [3:0]            in_fault_slot = '0;
  logic [7:0]            in_link_end_low = '0;
  logic [7:0]            in_link_end_high = '0;
  logic [7:0]            in_dest_node = '0;
  logic                  out_valid;
  logic [2:0]            out_port;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow copy of the block's registers and link table.
  logic [7:0] cur_router = 8'd0;
  logic [4:0] cur_cols = 5'd4;
  logic [4:0] cur_faults = 5'd0;
  logic [7:0] link_lo [MAX_FAULTS];
  logic [7:0] link_hi [MAX_FAULTS];

  port_t pending_ports [$];

  bit gaps_on = 1'b1;
  int n_errs = 0;
  int n_loads = 0;
  int n_routes = 0;
  int n_checked = 0;
  int n_settings = 0;
  int idle_cycles = 0;

  fault_aware_mesh_route_select i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_fault_slot    (in_fault_slot),
    .in_link_end_low  (in_link_end_low),
    .in_link_end_high (in_link_end_high),
    .in_dest_node     (in_dest_node),
    .out_valid        (out_valid),
    .out_port         (out_port),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #10ns clk = 1'b1;
    #10ns clk = 1'b0;
  end

  // Pick the output port for dest from the shadow state. Neighbour ids stay
  // signed ints so ids off the mesh (below 0 or past 255) never hit an entry.
  function automatic port_t route_port(logic [7:0] dest);
    int    cols, cnt, rid, did, row, col, drow, dcol;
    int    n_e, n_w, n_n, n_s, hn, vn, lo, hi;
    port_t hdir, vdir;
    bit    hmark, vmark, pick_v;
    cols = (cur_cols == 0) ? 1 : int'(cur_cols);
    cnt  = (cur_faults > MAX_FAULTS) ? MAX_FAULTS : int'(cur_faults);
    rid  = int'(cur_router);
    did  = int'(dest);
    row  = rid / cols;
    col  = rid % cols;
    drow = did / cols;
    dcol = did % cols;
    if (row == drow && col == dcol) return PORT_LOCAL;
    hdir = PORT_NONE;
    vdir = PORT_NONE;
    if (dcol > col) hdir = PORT_EAST;
    else if (dcol < col) hdir = PORT_WEST;
    if (drow < row) vdir = PORT_NORTH;
    else if (drow > row) vdir = PORT_SOUTH;
    n_e = rid + 1;
    n_w = rid - 1;
    n_n = rid - cols;
    n_s = rid + cols;
    // Drop a direction only when its own link is listed, lower id first.
    for (int i = 0; i < cnt; i++) begin
      lo = int'(link_lo[i]);
      hi = int'(link_hi[i]);
      if (rid == lo) begin
        if (hi == n_e && hdir == PORT_EAST) hdir = PORT_NONE;
        if (hi == n_s && vdir == PORT_SOUTH) vdir = PORT_NONE;
      end
      if (rid == hi) begin
        if (lo == n_w && hdir == PORT_WEST) hdir = PORT_NONE;
        if (lo == n_n && vdir == PORT_NORTH) vdir = PORT_NONE;
      end
    end
    if (hdir == PORT_NONE) return vdir;
    if (vdir == PORT_NONE) return hdir;
    // Both open: avoid a neighbour touching any fault, else break the tie by
    // router id parity.
    hn = (hdir == PORT_EAST) ? n_e : n_w;
    vn = (vdir == PORT_NORTH) ? n_n : n_s;
    hmark = 1'b0;
    vmark = 1'b0;
    for (int i = 0; i < cnt; i++) begin
      if (hn == int'(link_lo[i]) || hn == int'(link_hi[i])) hmark = 1'b1;
      if (vn == int'(link_lo[i]) || vn == int'(link_hi[i])) vmark = 1'b1;
    end
    pick_v = (hmark == vmark) ? cur_router[0] : hmark;
    return pick_v ? vdir : hdir;
  endfunction

  // Build a real mesh link next to the router or one of its neighbours,
  // lower id first, so the table actually bites on the routes.
  function automatic void pick_link(output logic [7:0] lo, output logic [7:0] hi);
    int         cols, ctr, other;
    logic [7:0] tmp;
    cols = (cur_cols == 0) ? 1 : int'(cur_cols);
    case ($urandom_range(0, 4))
      0: ctr = int'(cur_router);
      1: ctr = int'(cur_router) + 1;
      2: ctr = int'(cur_router) - 1;
      3: ctr = int'(cur_router) + cols;
      default: ctr = int'(cur_router) - cols;
    endcase
    other = ctr + (($urandom_range(0, 1) == 1) ? 1 : cols);
    lo = ctr[7:0];
    hi = other[7:0];
    if (lo > hi) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    n_errs++;
  endtask

  // Drive one beat, hold it until taken, then update the shadow state.
  // Start is left high so back-to-back beats need no extra edge.
  task automatic send_item(req_t kind, logic [3:0] slot, logic [7:0] lo,
                           logic [7:0] hi, logic [7:0] dest);
    if (gaps_on && $urandom_range(0, 99) < 6) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start            <= 1'b1;
    in_req_type      <= kind;
    in_fault_slot    <= slot;
    in_link_end_low  <= lo;
    in_link_end_high <= hi;
    in_dest_node     <= dest;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (kind == REQ_LOAD) begin
      link_lo[slot] = lo;
      link_hi[slot] = hi;
      n_loads++;
    end else begin
      pending_ports.push_back(route_port(dest));
      n_routes++;
    end
  endtask

  task automatic route_to(logic [7:0] dest);
    send_item(REQ_ROUTE, 4'($urandom), 8'($urandom), 8'($urandom), dest);
  endtask

  task automatic load_link(logic [3:0] slot, logic [7:0] lo, logic [7:0] hi);
    send_item(REQ_LOAD, slot, lo, hi, 8'($urandom));
  endtask

  // Drop start, wait for the pipe to empty, then write all three registers.
  task automatic program_regs(logic [7:0] id_val, logic [7:0] cols_val,
                              logic [7:0] cnt_val);
    logic [7:0] vals [3];
    cfg_idx_t   idx;
    vals[0] = id_val;
    vals[1] = cols_val;
    vals[2] = cnt_val;
    start <= 1'b0;
    while (pending_ports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int k = 0; k < 3; k++) begin
      idx = cfg_idx_t'(k);
      if (gaps_on && $urandom_range(0, 99) < 6) begin
        cfg_valid <= 1'b0;
        @(posedge clk);
      end
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= vals[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx)
        CFG_ROUTER_ID:    cur_router = vals[k];
        CFG_MESH_COLUMNS: cur_cols   = vals[k][4:0];
        CFG_FAULT_COUNT:  cur_faults = vals[k][4:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // Reset values: router 0, four columns, empty table. Route to itself and to
  // the far corner; the corner tie goes horizontal since id 0 is even, and
  // the north and west neighbours of node 0 lie off the mesh.
  task automatic test_local_and_open();
    route_to(8'd0);
    route_to(8'd255);
  endtask

  // Router 5 in a four-column mesh: neighbours north 1, east 6, south 9,
  // west 4. Walk the fault count up so links drop out one by one.
  task automatic test_dead_links();
    load_link(4'd0, 8'd6, 8'd5);    // reversed east link: not recognized
    load_link(4'd1, 8'd9, 8'd13);   // touches the south neighbour only
    load_link(4'd2, 8'd4, 8'd5);    // west link
    load_link(4'd3, 8'd1, 8'd5);    // north link
    // Reversed entry keeps east open but marks node 6: go south.
    program_regs(8'd5, 8'd4, 8'd1);
    route_to(8'd10);
    // South neighbour marked: go west.
    program_regs(8'd5, 8'd4, 8'd2);
    route_to(8'd8);
    // West and north dead.
    program_regs(8'd5, 8'd4, 8'd4);
    route_to(8'd0);
    route_to(8'd8);
    route_to(8'd2);
    route_to(8'd5);
    // Kill east too: both productive links gone toward the north-east.
    load_link(4'd0, 8'd5, 8'd6);
    route_to(8'd2);
    route_to(8'd15);
  endtask

  // Column count of zero behaves as one, a sixteen-column mesh, top id, even-id tie.
  task automatic test_mesh_extremes();
    program_regs(8'd255, 8'd0, 8'd0);
    route_to(8'd255);
    route_to(8'd0);
    program_regs(8'd255, 8'd16, 8'd0);
    route_to(8'd0);
    program_regs(8'd4, 8'd4, 8'd0);
    route_to(8'd10);
  endtask

  // Fill the whole table first so no count setting can expose an unwritten
  // entry, then run phases under different register settings.
  task automatic test_random_traffic();
    int         dst, cols;
    logic [7:0] lo, hi, id_v, col_v, cnt_v;
    for (int k = 0; k < MAX_FAULTS; k++) begin
      pick_link(lo, hi);
      load_link(4'(k), lo, hi);
    end
    for (int ph = 0; ph < 8; ph++) begin
      // Phase 0 and 1 hit the register extremes, including upper data bits
      // that the five-bit registers must drop and a count past the table.
      case (ph)
        0: begin
          id_v  = 8'd0;
          col_v = 8'd0;
          cnt_v = 8'd16;
        end
        1: begin
          id_v  = 8'd255;
          col_v = 8'hFF;
          cnt_v = 8'hFF;
        end
        2: begin
          id_v  = 8'($urandom);
          col_v = 8'd16;
          cnt_v = 8'd0;
        end
        default: begin
          id_v  = 8'($urandom);
          col_v = 8'($urandom_range(1, 16)) | 8'($urandom_range(0, 7) << 5);
          cnt_v = 8'($urandom_range(0, 16)) | 8'($urandom_range(0, 7) << 5);
        end
      endcase
      // Run phases 3 and 4 without any input gaps.
      gaps_on = !(ph == 3 || ph == 4);
      program_regs(id_v, col_v, cnt_v);
      cols = (cur_cols == 0) ? 1 : int'(cur_cols);
      for (int k = 0; k < 100; k++) begin
        if ($urandom_range(0, 99) < 25) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: pick_link(lo, hi);
            7: pick_link(hi, lo);
            default: begin
              lo = 8'($urandom);
              hi = 8'($urandom);
            end
          endcase
          load_link(4'($urandom), lo, hi);
        end else begin
          case ($urandom_range(0, 7))
            0: dst = int'(cur_router);
            1, 2, 3, 4:
              dst = int'(cur_router) + $urandom_range(0, 4) - 2
                    + cols * ($urandom_range(0, 4) - 2);
            default: dst = int'($urandom_range(0, 255));
          endcase
          route_to(dst[7:0]);
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  // Check each strobe against the oldest expected port.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_ports.size() == 0) begin
        report_mismatch($sformatf("unexpected result, port %0d", out_port));
      end else begin
        if (out_port !== pending_ports[0]) begin
          report_mismatch($sformatf("port got %0d want %0d (%s)", out_port,
                                    pending_ports[0], pending_ports[0].name()));
        end
        void'(pending_ports.pop_front());
        n_checked++;
      end
    end
  end

  // Watchdog: restart on any beat on any channel.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               idle_cycles, pending_ports.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < MAX_FAULTS; i++) begin
      link_lo[i] = '0;
      link_hi[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_local_and_open();
    test_dead_links();
    test_mesh_extremes();
    test_random_traffic();

    // Drain: hold start low and let the last results come out.
    start <= 1'b0;
    while (pending_ports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_ports.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_ports.size()));
    end

    $display("covered %0d route beats and %0d table loads under %0d register settings",
             n_routes, n_loads, n_settings);
    $display("checked %0d result beats, %0d mismatches", n_checked, n_errs);
    if (n_errs == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
